[src/hk_pkg.sv]
`timescale 1ns / 1ps
package hk_pkg;
  localparam int MAX_CITIES_DEF = 12;
  localparam int COORD_BITS_DEF = 16;
  localparam int COST_BITS_DEF  = 32;
  localparam int FIELD_COORD    = 16;
  localparam int FIELD_COST     = 32;
  localparam int FIELD_TOTAL    = 5;

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_SOLVE = 1'b1
  } req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DLOAD,
    ST_DSQ,
    ST_DROOT,
    ST_DWRITE,
    ST_SUBNEXT,
    ST_SUBCITY,
    ST_PRVSTEP,
    ST_PRVRD,
    ST_PRVACC,
    ST_SUBWRITE,
    ST_FINSTEP,
    ST_FINRD,
    ST_FINACC,
    ST_OUT
  } state_t;
endpackage

[src/held_karp_tour_cost_core.sv]
`timescale 1ns / 1ps
// Held-Karp exact tour cost engine.
// Input channel (in_valid/in_ready) carries one beat per request: req_type 0
// adds a city (in_city_x, in_city_y), req_type 1 solves the loaded set.
// An add beat gives no result beat. Adds beyond
// MAX_CITIES are dropped and reported in out_cities_dropped of the next solve.
// A solve gives one result beat on out_valid/out_ready: minimum closed tour
// cost in unsigned Q.8, a saturation flag, the drop flag and the city count.
// A solve of zero or one city goes straight to the result with cost zero.
// Otherwise: N*N distance entries, each built by load, square,
// COORD_BITS+9 bit-serial square root steps, a closing step and the
// write, then the subset pass over every odd subset and every city but
// city 0, then the final closure; each predecessor city needs one read of
// the subset table memory (one read port, registered) and one of the
// distance memory.
// The block takes no new beat while a solve runs or its result waits; a
// stalled receiver simply holds the result in the output register.
// Reset (synchronous, rst_n low) clears the city count, the drop flag and
// the control state; coordinate and table memories are left as they are.
module held_karp_tour_cost_core
  import hk_pkg::*;
#(
  parameter int MAX_CITIES = MAX_CITIES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COST_BITS  = COST_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_req_type,
  input  logic signed [FIELD_COORD-1:0] in_city_x,
  input  logic signed [FIELD_COORD-1:0] in_city_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [FIELD_COST-1:0]    out_tour_cost,
  output logic                     out_cost_saturated,
  output logic                     out_cities_dropped,
  output logic [FIELD_TOTAL-1:0]   out_city_total
);
  localparam int CB   = $clog2(MAX_CITIES);
  localparam int NB   = $clog2(MAX_CITIES + 1);
  localparam int DD   = MAX_CITIES * MAX_CITIES;
  localparam int DAB  = $clog2(DD);
  localparam int SD   = (1 << MAX_CITIES) * MAX_CITIES;
  localparam int SAB  = $clog2(SD);
  localparam int DIFB = COORD_BITS + 1;
  localparam int SQB  = 2 * DIFB;
  localparam int RADB = SQB + 16;
  localparam int RB   = RADB / 2;
  localparam int OUTB = (COST_BITS < FIELD_COST) ? COST_BITS : FIELD_COST;
  localparam int ACCW = RB + NB;
  localparam int ACCB = (ACCW > OUTB) ? ACCW : OUTB + 1;
  localparam logic [ACCB-1:0] LIMIT = {{(ACCB-OUTB){1'b0}}, {OUTB{1'b1}}};
  localparam logic [ACCB-1:0] INF   = {ACCB{1'b1}};
  localparam logic [MAX_CITIES:0] ONE_M = {{MAX_CITIES{1'b0}}, 1'b1};

  // memories
  logic signed [COORD_BITS-1:0] xmem [MAX_CITIES];
  logic signed [COORD_BITS-1:0] ymem [MAX_CITIES];
  logic [RB-1:0]   dmem [DD];
  logic [ACCB-1:0] smem [SD];

  state_t state_r, state_nxt;
  logic [NB-1:0] count_r;
  logic          drop_r;
  logic [CB-1:0] ci_r, cj_r;
  logic [MAX_CITIES:0] mask_r;
  logic [MAX_CITIES-1:0] prev_r;
  logic signed [COORD_BITS-1:0] xa_r, ya_r, xb_r, yb_r;
  logic [RADB-1:0] rad_r;
  logic [RB-1:0]   root_r;
  logic [RB+1:0]   rem_r;
  logic [$clog2(RB+1)-1:0] it_r;
  logic [ACCB-1:0] best_r;
  logic [RB-1:0]   drd_r;
  logic [ACCB-1:0] srd_r;
  logic            first_r;
  logic [FIELD_COST-1:0] ocost_r;
  logic            osat_r, odrop_r, ovalid_r;
  logic [FIELD_TOTAL-1:0] ototal_r;

  assign in_ready = (state_r == ST_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_tour_cost = ocost_r;
  assign out_cost_saturated = osat_r;
  assign out_cities_dropped = odrop_r;
  assign out_city_total = ototal_r;

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  // squared distance of the loaded pair
  logic signed [DIFB-1:0] dx, dy;
  logic [DIFB-1:0] ax, ay;
  logic [SQB-1:0] sq;
  always_comb begin
    dx = DIFB'(xa_r) - DIFB'(xb_r);
    dy = DIFB'(ya_r) - DIFB'(yb_r);
    ax = dx[DIFB-1] ? DIFB'(-dx) : DIFB'(dx);
    ay = dy[DIFB-1] ? DIFB'(-dy) : DIFB'(dy);
    sq = SQB'(ax) * SQB'(ax) + SQB'(ay) * SQB'(ay);
  end

  // one restoring square-root step, two radicand bits per cycle
  logic [RB+1:0] trial, rem_sh;
  always_comb begin
    rem_sh = {rem_r[RB-1:0], rad_r[RADB-1 -: 2]};
    trial  = rem_sh - {root_r, 2'b01};
  end

  logic [MAX_CITIES-1:0] mlow;
  logic [MAX_CITIES-1:0] full_m;
  logic [ACCB-1:0] cand;
  logic ilast_n, jlast_n;
  logic fin_rd;
  always_comb begin
    mlow    = mask_r[MAX_CITIES-1:0];
    full_m  = MAX_CITIES'((ONE_M << count_r) - ONE_M);
    cand    = srd_r + ACCB'(drd_r);
    ilast_n = (NB'(ci_r) + 1'b1) >= count_r;
    jlast_n = (NB'(cj_r) + 1'b1) >= count_r;
    fin_rd  = (state_r == ST_FINSTEP) || (state_r == ST_FINRD);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:
        if (in_beat && in_req_type == REQ_SOLVE) begin
          state_nxt = (count_r < NB'(2)) ? ST_OUT : ST_DLOAD;
        end
      ST_DLOAD:    state_nxt = ST_DSQ;
      ST_DSQ:      state_nxt = ST_DROOT;
      ST_DROOT:    if (it_r == '0) state_nxt = ST_DWRITE;
      ST_DWRITE:
        if (jlast_n && ilast_n) state_nxt = ST_SUBNEXT;
        else state_nxt = ST_DLOAD;
      ST_SUBNEXT:
        if (mask_r > {1'b0, full_m}) state_nxt = ST_FINSTEP;
        else state_nxt = ST_SUBCITY;
      ST_SUBCITY:
        if (!mlow[ci_r]) state_nxt = ilast_n ? ST_SUBNEXT : ST_SUBCITY;
        else state_nxt = ST_PRVSTEP;
      ST_PRVSTEP:
        if (prev_r[cj_r] && cj_r != '0) state_nxt = ST_PRVRD;
        else if (jlast_n) state_nxt = ST_SUBWRITE;
      ST_PRVRD:    state_nxt = ST_PRVACC;
      ST_PRVACC:   state_nxt = jlast_n ? ST_SUBWRITE : ST_PRVSTEP;
      ST_SUBWRITE: state_nxt = ilast_n ? ST_SUBNEXT : ST_SUBCITY;
      ST_FINSTEP:  state_nxt = ST_FINRD;
      ST_FINRD:    state_nxt = ST_FINACC;
      ST_FINACC:   state_nxt = ilast_n ? ST_OUT : ST_FINSTEP;
      ST_OUT:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // city store and load control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
    end else if (in_beat && in_req_type == REQ_ADD) begin
      if (count_r < NB'(MAX_CITIES)) count_r <= count_r + 1'b1;
      else drop_r <= 1'b1;
    end else if (state_r == ST_OUT) begin
      count_r <= '0;
      drop_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && in_req_type == REQ_ADD && count_r < NB'(MAX_CITIES)) begin
      xmem[count_r[CB-1:0]] <= COORD_BITS'(in_city_x);
      ymem[count_r[CB-1:0]] <= COORD_BITS'(in_city_y);
    end
  end

  // direct distance from city 0, kept in a flop copy of row zero
  logic [RB-1:0] row0 [MAX_CITIES];
  logic [RB-1:0] dmem_i0;
  assign dmem_i0 = row0[ci_r];
  always_ff @(posedge clk) begin
    if (state_r == ST_DWRITE && ci_r == '0) row0[cj_r] <= root_r;
  end

  // datapath: distance build, subset pass, final closure
  always_ff @(posedge clk) begin
    xa_r <= xmem[ci_r];
    ya_r <= ymem[ci_r];
    xb_r <= xmem[cj_r];
    yb_r <= ymem[cj_r];
    drd_r <= dmem[fin_rd ? DAB'(ci_r) * DAB'(MAX_CITIES)
                         : DAB'(cj_r) * DAB'(MAX_CITIES) + DAB'(ci_r)];
    srd_r <= smem[fin_rd
                  ? SAB'(full_m) * SAB'(MAX_CITIES) + SAB'(ci_r)
                  : SAB'(prev_r) * SAB'(MAX_CITIES) + SAB'(cj_r)];
    unique case (state_r)
      ST_IDLE: begin
        ci_r <= '0;
        cj_r <= '0;
        mask_r <= (MAX_CITIES+1)'(1);
      end
      ST_DSQ: begin
        rad_r  <= {sq, 16'h0000};
        rem_r  <= '0;
        root_r <= '0;
        it_r   <= ($clog2(RB+1))'(RB);
      end
      ST_DROOT: begin
        if (it_r != '0) begin
          rad_r <= rad_r << 2;
          if (!trial[RB+1]) begin
            rem_r  <= trial;
            root_r <= {root_r[RB-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[RB-2:0], 1'b0};
          end
          it_r <= it_r - 1'b1;
        end
      end
      ST_DWRITE: begin
        dmem[DAB'(ci_r) * DAB'(MAX_CITIES) + DAB'(cj_r)] <= root_r;
        if (jlast_n) begin
          cj_r <= '0;
          ci_r <= ci_r + 1'b1;
        end else begin
          cj_r <= cj_r + 1'b1;
        end
      end
      ST_SUBNEXT: begin
        mask_r <= mask_r + (MAX_CITIES+1)'(2);
        ci_r   <= CB'(1);
      end
      ST_SUBCITY: begin
        prev_r  <= mlow & ~(MAX_CITIES'(1) << ci_r);
        cj_r    <= '0;
        best_r  <= INF;
        first_r <= 1'b1;
        if (!mlow[ci_r]) ci_r <= ci_r + 1'b1;
      end
      ST_PRVSTEP:
        if (!(prev_r[cj_r] && cj_r != '0) && !jlast_n) cj_r <= cj_r + 1'b1;
      ST_PRVACC: begin
        if (first_r || cand < best_r) best_r <= cand;
        first_r <= 1'b0;
        if (!jlast_n) cj_r <= cj_r + 1'b1;
      end
      ST_SUBWRITE: begin
        smem[SAB'(mlow) * SAB'(MAX_CITIES) + SAB'(ci_r)] <=
          (prev_r == MAX_CITIES'(1)) ? ACCB'(dmem_i0) : best_r;
        ci_r <= ci_r + 1'b1;
        if (ilast_n) begin
          best_r <= INF;
          first_r <= 1'b1;
        end
      end
      ST_FINACC: begin
        if (first_r || cand < best_r) best_r <= cand;
        first_r <= 1'b0;
        ci_r <= ci_r + 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (state_r == ST_OUT) begin
      ovalid_r <= 1'b1;
      odrop_r  <= drop_r;
      ototal_r <= FIELD_TOTAL'(count_r);
      if (count_r < NB'(2)) begin
        ocost_r <= '0;
        osat_r  <= 1'b0;
      end else if (best_r > LIMIT) begin
        ocost_r <= FIELD_COST'(LIMIT);
        osat_r  <= 1'b1;
      end else begin
        ocost_r <= FIELD_COST'(best_r);
        osat_r  <= 1'b0;
      end
    end else if (ovalid_r && out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("accepted while busy");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NB'(MAX_CITIES)) else $error("city count out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ready) |=> (ovalid_r && $stable(ocost_r)))
    else $error("result lost under stall");
  a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> (count_r == '0 || $past(in_beat)))
    else $error("count not cleared");
endmodule
